// ----- rtl/wlsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_pkg
// Types and constants shared by the windowed least-squares line fit.
// ----------------------------------------------------------------------------
package wlsf_pkg;

    localparam int WIDE_W = 128;
    localparam int MAG_W  = 64;
    localparam int OPD_W  = 65;
    localparam int Q_W    = 34;
    localparam int SH_W   = 5;
    localparam int PT_W   = 20;

    localparam logic [Q_W-1:0]  DIV_CAP  = 34'h2_0000_0000;
    localparam logic [16:0]     R2_ONE   = 17'd65536;
    localparam logic [SH_W-1:0] SLOPE_SH = 5'd16;
    localparam logic [SH_W-1:0] ICPT_SH  = 5'd6;
    localparam logic [SH_W-1:0] R2_SH    = 5'd16;

    localparam logic [PT_W-1:0] WINDOW_LOW_RST  = 20'h80000;
    localparam logic [PT_W-1:0] WINDOW_HIGH_RST = 20'h7FFFF;

    typedef enum logic [0:0] {
        CFG_WINDOW_LOW  = 1'b0,
        CFG_WINDOW_HIGH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FIT_OK        = 2'd0,
        FIT_NO_POINTS = 2'd1,
        FIT_ZERO_VAR  = 2'd2
    } t_fit_status;

    typedef enum logic [3:0] {
        ST_ACC, ST_CHK, ST_MGO, ST_MWAIT, ST_ZCHK, ST_DGO, ST_DWAIT, ST_EMIT
    } t_state;

    // products, in the order the controller runs them
    typedef enum logic [3:0] {
        MOP_NSXX, MOP_SXSX, MOP_NSXY, MOP_SXSY, MOP_NSYY, MOP_SYSY,
        MOP_SYSXX, MOP_SXSXY, MOP_NUM2, MOP_DEN2
    } t_mop;

    typedef enum logic [1:0] {
        DOP_SLOPE, DOP_ICPT, DOP_R2
    } t_dop;

    typedef struct packed {
        logic        accept;
        logic        clear_res;
        logic        mul_start;
        logic        mul_latch;
        t_mop        mop;
        logic        div_start;
        logic        div_latch;
        t_dop        dop;
        logic        emit;
        t_fit_status status;
    } t_cmd;

    typedef struct packed {
        logic tally_zero;
        logic denx_zero;
        logic deny_zero;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/wlsf_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_mul
// Shift-and-add multiplier, 64 x 64 magnitudes to a signed 128-bit product,
// one multiplier bit per cycle, finishing early once the rest are zero.
// ----------------------------------------------------------------------------
module wlsf_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wlsf_pkg::MAG_W-1:0] i_a_mag,
    input  logic [wlsf_pkg::MAG_W-1:0] i_b_mag,
    input  logic                       i_neg,
    output logic                       o_done,
    output logic [wlsf_pkg::WIDE_W-1:0] o_prod
);
    import wlsf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [WIDE_W-1:0] r_a;
    logic [MAG_W-1:0]  r_b;
    logic [WIDE_W-1:0] r_acc;
    logic [WIDE_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= WIDE_W'(i_a_mag);
            r_b   <= i_b_mag;
            r_acc <= '0;
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_prod <= r_neg ? (WIDE_W'(0) - r_acc) : r_acc;
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[WIDE_W-2:0], 1'b0};
                r_b <= {1'b0, r_b[MAG_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- rtl/wlsf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_div
// Restoring divider: round(num * 2^sh / den), capped at 2^33, one quotient
// bit per cycle, then a closing rounding step.
// ----------------------------------------------------------------------------
module wlsf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wlsf_pkg::WIDE_W-1:0] i_num,
    input  logic [wlsf_pkg::SH_W-1:0]   i_sh,
    input  logic [wlsf_pkg::WIDE_W-1:0] i_den,
    output logic                        o_done,
    output logic [wlsf_pkg::Q_W-1:0]    o_quot
);
    import wlsf_pkg::*;

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    logic [7:0]        r_cnt;
    logic [WIDE_W-1:0] r_num;
    logic [WIDE_W-1:0] r_den;
    logic [WIDE_W:0]   r_rem;
    logic [Q_W-1:0]    r_q;
    logic              r_big;
    logic [Q_W-1:0]    r_quot;

    logic [WIDE_W:0]   rem_sh;
    logic              ge;
    logic [WIDE_W:0]   rem_nx;
    logic [Q_W-1:0]    q_nx;
    logic [WIDE_W:0]   half;
    logic              up;
    logic [Q_W:0]      q_rnd;

    always_comb begin
        rem_sh = {r_rem[WIDE_W-1:0], r_num[WIDE_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        q_nx   = r_big ? r_q : {r_q[Q_W-2:0], ge};
        half   = {1'b0, r_den} - r_rem;
        up     = r_rem >= half;
        q_rnd  = {1'b0, r_q} + (Q_W+1)'(up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_cnt <= 8'd127 + 8'(i_sh);
        end else if (r_busy) begin
            r_num <= {r_num[WIDE_W-2:0], 1'b0};
            r_rem <= rem_nx;
            r_q   <= q_nx;
            r_big <= r_big | (q_nx >= DIV_CAP);
            r_cnt <= r_cnt - 8'd1;
        end else if (r_fin) begin
            if (r_big || q_rnd > (Q_W+1)'(DIV_CAP)) begin
                r_quot <= DIV_CAP;
            end else begin
                r_quot <= q_rnd[Q_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/wlsf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_datapath
// Window registers, running sums, the shared multiplier and divider, the
// fit terms and the output register.
// ----------------------------------------------------------------------------
module wlsf_datapath #(
    parameter int MAX_POINTS = 1024,
    parameter int CW         = 11,
    parameter int TD_W       = 96
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [0:0]                i_cfg_index,
    input  logic [19:0]               i_cfg_data,
    input  logic [39:0]               i_point,
    input  wlsf_pkg::t_cmd            i_cmd,
    output wlsf_pkg::t_sts            o_sts,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [TD_W-1:0]           o_m_tdata,
    output logic [1:0]                o_m_tuser
);
    import wlsf_pkg::*;

    localparam int SW = PT_W + CW;
    localparam int PW = 2*PT_W - 1 + CW;
    localparam logic [CW-1:0] MAXN = CW'(MAX_POINTS);

    logic signed [PT_W-1:0] r_low, r_high;
    logic signed [SW-1:0]   r_sx, r_sy;
    logic signed [PW-1:0]   r_sxx, r_sxy, r_syy;
    logic [CW-1:0]          r_tally;

    logic [WIDE_W-1:0] r_tmp, r_denx, r_numx, r_deny, r_numb, r_den2;
    logic [31:0]       r_slope, r_icpt;
    logic [16:0]       r_r2;

    logic              r_m_valid;
    logic [31:0]       r_o_slope, r_o_icpt;
    logic [16:0]       r_o_r2;
    logic [CW-1:0]     r_o_tally;
    t_fit_status       r_o_status;

    logic signed [PT_W-1:0]     x, y;
    logic signed [2*PT_W-1:0]   pxx, pxy, pyy;
    logic                       in_win;
    logic signed [OPD_W-1:0]    opa, opb, absa, absb;
    logic [WIDE_W-1:0]          mx, mb;
    logic [WIDE_W-1:0]          div_num, div_den;
    logic [SH_W-1:0]            div_sh;
    logic                       mul_done, div_done;
    logic [WIDE_W-1:0]          prod;
    logic [Q_W-1:0]             quot;

    function automatic logic [31:0] sat_q16(input logic [Q_W-1:0] mag, input logic neg);
        logic [Q_W-1:0] m;
        begin
            m = mag;
            if (neg) begin
                if (m > 34'h0_8000_0000) m = 34'h0_8000_0000;
                sat_q16 = 32'd0 - m[31:0];
            end else begin
                if (m > 34'h0_7FFF_FFFF) m = 34'h0_7FFF_FFFF;
                sat_q16 = m[31:0];
            end
        end
    endfunction

    assign x   = i_point[PT_W-1:0];
    assign y   = i_point[2*PT_W-1:PT_W];
    assign pxx = x * x;
    assign pxy = x * y;
    assign pyy = y * y;
    assign in_win = (x >= r_low) && (x < r_high) && (r_tally < MAXN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= WINDOW_LOW_RST;
            r_high <= WINDOW_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_LOW:  r_low  <= i_cfg_data;
                CFG_WINDOW_HIGH: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_sxy   <= '0;
            r_syy   <= '0;
            r_tally <= '0;
        end else if (i_cmd.accept && in_win) begin
            r_sx    <= r_sx + SW'(x);
            r_sy    <= r_sy + SW'(y);
            r_sxx   <= r_sxx + PW'(pxx);
            r_sxy   <= r_sxy + PW'(pxy);
            r_syy   <= r_syy + PW'(pyy);
            r_tally <= r_tally + CW'(1);
        end
    end

    assign mx = r_numx[WIDE_W-1] ? (WIDE_W'(0) - r_numx) : r_numx;
    assign mb = r_numb[WIDE_W-1] ? (WIDE_W'(0) - r_numb) : r_numb;

    // operand pairs for the shared multiplier
    always_comb begin
        case (i_cmd.mop)
            MOP_NSXX:  begin opa = OPD_W'(r_tally); opb = OPD_W'(r_sxx); end
            MOP_SXSX:  begin opa = OPD_W'(r_sx);    opb = OPD_W'(r_sx);  end
            MOP_NSXY:  begin opa = OPD_W'(r_tally); opb = OPD_W'(r_sxy); end
            MOP_SXSY:  begin opa = OPD_W'(r_sx);    opb = OPD_W'(r_sy);  end
            MOP_NSYY:  begin opa = OPD_W'(r_tally); opb = OPD_W'(r_syy); end
            MOP_SYSY:  begin opa = OPD_W'(r_sy);    opb = OPD_W'(r_sy);  end
            MOP_SYSXX: begin opa = OPD_W'(r_sy);    opb = OPD_W'(r_sxx); end
            MOP_SXSXY: begin opa = OPD_W'(r_sx);    opb = OPD_W'(r_sxy); end
            MOP_NUM2: begin
                opa = {1'b0, mx[MAG_W-1:0]};
                opb = {1'b0, mx[MAG_W-1:0]};
            end
            MOP_DEN2: begin
                opa = {1'b0, r_denx[MAG_W-1:0]};
                opb = {1'b0, r_deny[MAG_W-1:0]};
            end
            default: begin opa = '0; opb = '0; end
        endcase
        absa = opa[OPD_W-1] ? -opa : opa;
        absb = opb[OPD_W-1] ? -opb : opb;
    end

    always_comb begin
        case (i_cmd.dop)
            DOP_SLOPE: begin div_num = mx;    div_sh = SLOPE_SH; div_den = r_denx; end
            DOP_ICPT:  begin div_num = mb;    div_sh = ICPT_SH;  div_den = r_denx; end
            DOP_R2:    begin div_num = r_tmp; div_sh = R2_SH;    div_den = r_den2; end
            default:   begin div_num = '0;    div_sh = '0;       div_den = r_denx; end
        endcase
    end

    wlsf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a_mag (absa[MAG_W-1:0]),
        .i_b_mag (absb[MAG_W-1:0]),
        .i_neg   (opa[OPD_W-1] ^ opb[OPD_W-1]),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    wlsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_sh    (div_sh),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_latch) begin
            case (i_cmd.mop)
                MOP_SXSX:  r_denx <= r_tmp - prod;
                MOP_SXSY:  r_numx <= r_tmp - prod;
                MOP_SYSY:  r_deny <= r_tmp - prod;
                MOP_SXSXY: r_numb <= r_tmp - prod;
                MOP_DEN2:  r_den2 <= prod;
                default:   r_tmp  <= prod;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_res) begin
            r_slope <= '0;
            r_icpt  <= '0;
            r_r2    <= '0;
        end else if (i_cmd.div_latch) begin
            case (i_cmd.dop)
                DOP_SLOPE: r_slope <= sat_q16(quot, r_numx[WIDE_W-1]);
                DOP_ICPT:  r_icpt  <= sat_q16(quot, r_numb[WIDE_W-1]);
                DOP_R2:    r_r2    <= (quot > Q_W'(R2_ONE)) ? R2_ONE : quot[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_slope  <= r_slope;
            r_o_icpt   <= r_icpt;
            r_o_r2     <= r_r2;
            r_o_tally  <= r_tally;
            r_o_status <= i_cmd.status;
        end
    end

    assign o_sts.tally_zero = (r_tally == '0);
    assign o_sts.denx_zero  = (r_denx == '0);
    assign o_sts.deny_zero  = (r_deny == '0);
    assign o_sts.mul_done   = mul_done;
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = TD_W'({r_o_tally, r_o_r2, r_o_icpt, r_o_slope});
    assign o_m_tuser  = r_o_status;

endmodule

// ----- rtl/wlsf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlsf_ctrl
// Sequencer: takes points, then steps the closing fit through the shared
// multiplier and divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module wlsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    output logic           o_s_tready,
    input  wlsf_pkg::t_sts i_sts,
    output wlsf_pkg::t_cmd o_cmd
);
    import wlsf_pkg::*;

    t_state      r_state, n_state;
    t_mop        r_mop, n_mop;
    t_dop        r_dop, n_dop;
    t_fit_status r_stat, n_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_mop   <= MOP_NSXX;
            r_dop   <= DOP_SLOPE;
            r_stat  <= FIT_OK;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_dop   <= n_dop;
            r_stat  <= n_stat;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mop      = r_mop;
        n_dop      = r_dop;
        n_stat     = r_stat;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.mop    = r_mop;
        o_cmd.dop    = r_dop;
        o_cmd.status = r_stat;
        case (r_state)
            ST_ACC: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) n_state = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.clear_res = 1'b1;
                if (i_sts.tally_zero) begin
                    n_stat  = FIT_NO_POINTS;
                    n_state = ST_EMIT;
                end else begin
                    n_stat  = FIT_OK;
                    n_mop   = MOP_NSXX;
                    n_state = ST_MGO;
                end
            end
            ST_MGO: begin
                o_cmd.mul_start = 1'b1;
                n_state = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_latch = 1'b1;
                    case (r_mop)
                        MOP_SXSX: n_state = ST_ZCHK;
                        MOP_SXSXY: begin
                            n_dop   = DOP_SLOPE;
                            n_state = ST_DGO;
                        end
                        MOP_DEN2: begin
                            n_dop   = DOP_R2;
                            n_state = ST_DGO;
                        end
                        default: begin
                            n_mop   = t_mop'(r_mop + 4'd1);
                            n_state = ST_MGO;
                        end
                    endcase
                end
            end
            ST_ZCHK: begin
                if (i_sts.denx_zero) begin
                    n_stat  = FIT_ZERO_VAR;
                    n_state = ST_EMIT;
                end else begin
                    n_mop   = MOP_NSXY;
                    n_state = ST_MGO;
                end
            end
            ST_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_latch = 1'b1;
                    case (r_dop)
                        DOP_SLOPE: begin
                            n_dop   = DOP_ICPT;
                            n_state = ST_DGO;
                        end
                        DOP_ICPT: begin
                            // flat y leaves r squared at zero
                            if (i_sts.deny_zero) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_mop   = MOP_NUM2;
                                n_state = ST_MGO;
                            end
                        end
                        default: n_state = ST_EMIT;
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

endmodule

// ----- rtl/windowed_least_squares_line_fit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_least_squares_line_fit
// Least-squares line fit over the points whose x falls in a window.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while no fit runs; each point in the window
// is summed in the cycle it is accepted. A last point starts the fit: up to
// ten products on the shared shift-add multiplier and three divisions on the
// shared divider, with no point taken meanwhile. Reset (sync, active low)
// sets the window to [-524288, 524287) and clears the sums.
module windowed_least_squares_line_fit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side: [19:0] x_value, [39:20] y_value
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [39:0]         i_s_tdata,
    input  logic                i_s_tlast,
    // master side: [31:0] slope, [63:32] intercept, [80:64] r_squared,
    // then points_used, zero filled to whole bytes
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [((81+$clog2(MAX_POINTS+1)+7)/8)*8-1:0] o_m_tdata,
    // [1:0] fit_status
    output logic [1:0]          o_m_tuser,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data
);
    import wlsf_pkg::*;

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int TD_W = ((81 + CW + 7) / 8) * 8;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    wlsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wlsf_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW),
        .TD_W       (TD_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
